[rtl/aat_pkg.sv]
package aat_pkg;

    localparam int CW = 32;            // coordinate width
    localparam int FB = 16;            // fraction bits
    localparam int HW = CW - 1;        // half-extent width
    localparam int PW = 2 * CW;        // product width
    localparam int SW = 2 * CW + 2;    // mapped sum width, room for carry and translation
    localparam int LAT = 6;            // start beat to result strobe, in cycles

    localparam logic signed [CW-1:0] CMAX = {1'b0, {HW{1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {HW{1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] m_xx;
        logic signed [CW-1:0] m_xy;
        logic signed [CW-1:0] m_xt;
        logic signed [CW-1:0] m_yx;
        logic signed [CW-1:0] m_yy;
        logic signed [CW-1:0] m_yt;
        logic signed [CW-1:0] box_center_x;
        logic signed [CW-1:0] box_center_y;
        logic        [HW-1:0] box_half_x;
        logic        [HW-1:0] box_half_y;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] out_center_x;
        logic signed [CW-1:0] out_center_y;
        logic        [HW-1:0] out_half_x;
        logic        [HW-1:0] out_half_y;
        logic                 overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [CW-1:0] m_xx;
        logic signed [CW-1:0] m_xy;
        logic signed [CW-1:0] m_xt;
        logic signed [CW-1:0] m_yx;
        logic signed [CW-1:0] m_yy;
        logic signed [CW-1:0] m_yt;
        logic signed [CW-1:0] xs_lo;
        logic signed [CW-1:0] xs_hi;
        logic signed [CW-1:0] ys_lo;
        logic signed [CW-1:0] ys_hi;
        logic                 ovf;
    } t_corners;

    // corner k = 2*i + j, i picks the x side, j the y side
    typedef struct packed {
        logic [3:0][CW-1:0] tx;
        logic [3:0][CW-1:0] ty;
        logic               ovf;
    } t_mapped;

endpackage

[rtl/aat_corner.sv]
module aat_corner (
    input  logic              i_clk,
    input  aat_pkg::t_in_item i_item,
    output aat_pkg::t_corners o_corners
);

    aat_pkg::t_corners r_corners;
    aat_pkg::t_corners n_corners;

    logic signed [aat_pkg::CW:0] s_xlo, s_xhi, s_ylo, s_yhi;
    logic ov_xlo, ov_xhi, ov_ylo, ov_yhi;

    // clamp a one-bit-wider sum back to the coordinate range
    function automatic logic signed [aat_pkg::CW-1:0] clamp(
        input logic signed [aat_pkg::CW:0] v
    );
        if (v[aat_pkg::CW] == v[aat_pkg::CW-1]) begin
            return v[aat_pkg::CW-1:0];
        end
        return v[aat_pkg::CW] ? aat_pkg::CMIN : aat_pkg::CMAX;
    endfunction

    always_comb begin
        s_xlo = $signed({i_item.box_center_x[aat_pkg::CW-1], i_item.box_center_x})
              - $signed({2'b00, i_item.box_half_x});
        s_xhi = $signed({i_item.box_center_x[aat_pkg::CW-1], i_item.box_center_x})
              + $signed({2'b00, i_item.box_half_x});
        s_ylo = $signed({i_item.box_center_y[aat_pkg::CW-1], i_item.box_center_y})
              - $signed({2'b00, i_item.box_half_y});
        s_yhi = $signed({i_item.box_center_y[aat_pkg::CW-1], i_item.box_center_y})
              + $signed({2'b00, i_item.box_half_y});
        ov_xlo = s_xlo[aat_pkg::CW] != s_xlo[aat_pkg::CW-1];
        ov_xhi = s_xhi[aat_pkg::CW] != s_xhi[aat_pkg::CW-1];
        ov_ylo = s_ylo[aat_pkg::CW] != s_ylo[aat_pkg::CW-1];
        ov_yhi = s_yhi[aat_pkg::CW] != s_yhi[aat_pkg::CW-1];

        n_corners.m_xx  = i_item.m_xx;
        n_corners.m_xy  = i_item.m_xy;
        n_corners.m_xt  = i_item.m_xt;
        n_corners.m_yx  = i_item.m_yx;
        n_corners.m_yy  = i_item.m_yy;
        n_corners.m_yt  = i_item.m_yt;
        n_corners.xs_lo = clamp(s_xlo);
        n_corners.xs_hi = clamp(s_xhi);
        n_corners.ys_lo = clamp(s_ylo);
        n_corners.ys_hi = clamp(s_yhi);
        n_corners.ovf   = ov_xlo | ov_xhi | ov_ylo | ov_yhi;
    end

    always_ff @(posedge i_clk) begin
        r_corners <= n_corners;
    end

    assign o_corners = r_corners;

endmodule

[rtl/aat_map.sv]
module aat_map (
    input  logic              i_clk,
    input  aat_pkg::t_corners i_corners,
    output aat_pkg::t_mapped  o_mapped
);

    // product stage: four distinct products per output axis
    logic signed [aat_pkg::PW-1:0] r_pxa [2];
    logic signed [aat_pkg::PW-1:0] r_pxb [2];
    logic signed [aat_pkg::PW-1:0] r_pya [2];
    logic signed [aat_pkg::PW-1:0] r_pyb [2];
    logic signed [aat_pkg::CW-1:0] r_xt, r_yt;
    logic                          r_povf;

    aat_pkg::t_mapped r_mapped;
    aat_pkg::t_mapped n_mapped;

    // floor by the fraction bits, add translation, saturate; msb is the overflow flag
    function automatic logic [aat_pkg::CW:0] map_sat(
        input logic signed [aat_pkg::PW-1:0] pa,
        input logic signed [aat_pkg::PW-1:0] pb,
        input logic signed [aat_pkg::CW-1:0] mt
    );
        logic signed [aat_pkg::SW-1:0] sum;
        logic signed [aat_pkg::SW-1:0] top;
        sum = $signed({{2{pa[aat_pkg::PW-1]}}, pa}) + $signed({{2{pb[aat_pkg::PW-1]}}, pb});
        top = (sum >>> aat_pkg::FB)
            + $signed({{(aat_pkg::SW-aat_pkg::CW){mt[aat_pkg::CW-1]}}, mt});
        if ((&top[aat_pkg::SW-1:aat_pkg::CW-1]) || !(|top[aat_pkg::SW-1:aat_pkg::CW-1])) begin
            return {1'b0, top[aat_pkg::CW-1:0]};
        end
        return {1'b1, top[aat_pkg::SW-1] ? aat_pkg::CMIN : aat_pkg::CMAX};
    endfunction

    // operands are sign-extended 32-bit values, so each product is a 32x32 signed multiply
    always_ff @(posedge i_clk) begin
        r_pxa[0] <= aat_pkg::PW'(i_corners.m_xx) * aat_pkg::PW'(i_corners.xs_lo);
        r_pxa[1] <= aat_pkg::PW'(i_corners.m_xx) * aat_pkg::PW'(i_corners.xs_hi);
        r_pxb[0] <= aat_pkg::PW'(i_corners.m_xy) * aat_pkg::PW'(i_corners.ys_lo);
        r_pxb[1] <= aat_pkg::PW'(i_corners.m_xy) * aat_pkg::PW'(i_corners.ys_hi);
        r_pya[0] <= aat_pkg::PW'(i_corners.m_yx) * aat_pkg::PW'(i_corners.xs_lo);
        r_pya[1] <= aat_pkg::PW'(i_corners.m_yx) * aat_pkg::PW'(i_corners.xs_hi);
        r_pyb[0] <= aat_pkg::PW'(i_corners.m_yy) * aat_pkg::PW'(i_corners.ys_lo);
        r_pyb[1] <= aat_pkg::PW'(i_corners.m_yy) * aat_pkg::PW'(i_corners.ys_hi);
        r_xt     <= i_corners.m_xt;
        r_yt     <= i_corners.m_yt;
        r_povf   <= i_corners.ovf;
    end

    always_comb begin
        logic [aat_pkg::CW:0] rx, ry;
        logic any;
        any = r_povf;
        n_mapped.tx = '0;
        n_mapped.ty = '0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                rx = map_sat(r_pxa[i], r_pxb[j], r_xt);
                ry = map_sat(r_pya[i], r_pyb[j], r_yt);
                n_mapped.tx[2*i+j] = rx[aat_pkg::CW-1:0];
                n_mapped.ty[2*i+j] = ry[aat_pkg::CW-1:0];
                any = any | rx[aat_pkg::CW] | ry[aat_pkg::CW];
            end
        end
        n_mapped.ovf = any;
    end

    always_ff @(posedge i_clk) begin
        r_mapped <= n_mapped;
    end

    assign o_mapped = r_mapped;

endmodule

[rtl/aat_bound.sv]
module aat_bound (
    input  logic               i_clk,
    input  aat_pkg::t_mapped   i_mapped,
    output aat_pkg::t_out_item o_result
);

    logic signed [aat_pkg::CW-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic                          r_ovf;
    logic signed [aat_pkg::CW-1:0] n_minx, n_maxx, n_miny, n_maxy;

    logic signed [aat_pkg::CW:0] sum_x, sum_y, span_x, span_y;

    aat_pkg::t_out_item r_result;
    aat_pkg::t_out_item n_result;

    function automatic logic signed [aat_pkg::CW-1:0] smin(
        input logic signed [aat_pkg::CW-1:0] a,
        input logic signed [aat_pkg::CW-1:0] b
    );
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [aat_pkg::CW-1:0] smax(
        input logic signed [aat_pkg::CW-1:0] a,
        input logic signed [aat_pkg::CW-1:0] b
    );
        return (b > a) ? b : a;
    endfunction

    // two-level compare tree over the four corners
    always_comb begin
        n_minx = smin(smin(i_mapped.tx[0], i_mapped.tx[1]), smin(i_mapped.tx[2], i_mapped.tx[3]));
        n_maxx = smax(smax(i_mapped.tx[0], i_mapped.tx[1]), smax(i_mapped.tx[2], i_mapped.tx[3]));
        n_miny = smin(smin(i_mapped.ty[0], i_mapped.ty[1]), smin(i_mapped.ty[2], i_mapped.ty[3]));
        n_maxy = smax(smax(i_mapped.ty[0], i_mapped.ty[1]), smax(i_mapped.ty[2], i_mapped.ty[3]));
    end

    always_ff @(posedge i_clk) begin
        r_minx <= n_minx;
        r_maxx <= n_maxx;
        r_miny <= n_miny;
        r_maxy <= n_maxy;
        r_ovf  <= i_mapped.ovf;
    end

    // floor halving is an arithmetic shift; the span is never negative
    always_comb begin
        sum_x  = $signed({r_minx[aat_pkg::CW-1], r_minx}) + $signed({r_maxx[aat_pkg::CW-1], r_maxx});
        sum_y  = $signed({r_miny[aat_pkg::CW-1], r_miny}) + $signed({r_maxy[aat_pkg::CW-1], r_maxy});
        span_x = $signed({r_maxx[aat_pkg::CW-1], r_maxx}) - $signed({r_minx[aat_pkg::CW-1], r_minx});
        span_y = $signed({r_maxy[aat_pkg::CW-1], r_maxy}) - $signed({r_miny[aat_pkg::CW-1], r_miny});
        n_result.out_center_x = sum_x[aat_pkg::CW:1];
        n_result.out_center_y = sum_y[aat_pkg::CW:1];
        n_result.out_half_x   = span_x[aat_pkg::CW-1:1];
        n_result.out_half_y   = span_y[aat_pkg::CW-1:1];
        n_result.overflow     = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

[rtl/aabb_affine_transform_core.sv]
// Transforms a 2D box (signed Q16.16 center, unsigned Q15.16 half-extents) by a
// 2x3 affine matrix and returns the bounding box of the four mapped corners,
// saturated, with an overflow flag. One item is taken per clock: busy never rises,
// so start may be held high every cycle. Each result shows on o_result for exactly
// one cycle with o_valid high, once it has passed the input register, corner clamp,
// products, sum and saturate, min/max and center/half registers, in input order.
// The receiver cannot stall this block and must take every beat as it comes.
module aabb_affine_transform_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  aat_pkg::t_in_item  i_item,
    output logic               o_valid,
    output aat_pkg::t_out_item o_result
);

    logic [aat_pkg::LAT-1:0] r_vld;
    aat_pkg::t_in_item r_item;
    aat_pkg::t_corners corners;
    aat_pkg::t_mapped  mapped;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[aat_pkg::LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item <= i_item;
        end
    end

    aat_corner u_corner (
        .i_clk     (i_clk),
        .i_item    (r_item),
        .o_corners (corners)
    );

    aat_map u_map (
        .i_clk     (i_clk),
        .i_corners (corners),
        .o_mapped  (mapped)
    );

    aat_bound u_bound (
        .i_clk    (i_clk),
        .i_mapped (mapped),
        .o_result (o_result)
    );

    assign o_valid = r_vld[aat_pkg::LAT-1];

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(aat_pkg::LAT) o_valid)
        else $error("accepted beat did not produce a result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, aat_pkg::LAT))
        else $error("result strobe without a matching start beat");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy raised while results stream");

endmodule
